>>> sv/brbq_pkg.sv
// shared types and constants for the byte ring buffer queue
package brbq_pkg;

   localparam int DEPTH  = 4096;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int LEN_W  = 16;
   localparam int BYTE_W = 8;
   localparam int CMP_W  = (LEN_W > CNT_W) ? LEN_W : CNT_W;

   // packed widths of the stream ports
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_GET   = 2'd1,
      CMD_POP   = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TAKEN     = 3'd1,
      ST_NO_SPACE  = 3'd2,
      ST_UNDERFLOW = 3'd3,
      ST_BUSY      = 3'd4,
      ST_NONE      = 3'd5
   } status_type;

   typedef struct packed {
      status_type        status;
      logic [CNT_W-1:0]  granted;
      logic              last;
      logic [CNT_W-1:0]  used_count;
      logic              popped;
   } result_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } wr_type;

endpackage

>>> sv/brbq_store.sv
// byte store: one write port, one registered read port
module brbq_store (
   input  logic                          clock,
   input  brbq_pkg::wr_type              wr,
   input  logic                          rd_en,
   input  logic [brbq_pkg::ADDR_W-1:0]   rd_addr,
   output logic [brbq_pkg::BYTE_W-1:0]   rd_data
);

   logic [brbq_pkg::BYTE_W-1:0] mem [brbq_pkg::DEPTH];
   logic [brbq_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/brbq_ctrl.sv
// queue pointers, chunk and grant tracking, and per-item result logic
module brbq_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  brbq_pkg::cmd_type                   cmd,
   input  logic [brbq_pkg::LEN_W-1:0]          length,
   input  logic [brbq_pkg::BYTE_W-1:0]         data_in,
   input  logic                                allow_underflow,
   input  logic                                cfg_we,
   input  logic [brbq_pkg::CNT_W-1:0]          cfg_data,
   output brbq_pkg::result_type                res,
   output brbq_pkg::wr_type                    wr,
   output logic                                rd_en,
   output logic [brbq_pkg::ADDR_W-1:0]         rd_addr
);

   localparam logic [brbq_pkg::CNT_W-1:0] DEPTH_C = brbq_pkg::CNT_W'(brbq_pkg::DEPTH);

   logic [brbq_pkg::CNT_W-1:0]  cap_ff,   cap_in;
   logic [brbq_pkg::ADDR_W-1:0] head_ff,  head_in;
   logic [brbq_pkg::ADDR_W-1:0] wcur_ff,  wcur_in;
   logic [brbq_pkg::CNT_W-1:0]  used_ff,  used_in;
   logic [brbq_pkg::LEN_W-1:0]  crem_ff,  crem_in;
   logic [brbq_pkg::CNT_W-1:0]  ctot_ff,  ctot_in;
   logic                        cdisc_ff, cdisc_in;
   logic [brbq_pkg::CNT_W-1:0]  rrem_ff,  rrem_in;

   logic [brbq_pkg::CNT_W-1:0]  free_b;
   logic                        len_gt_free;
   logic                        len_gt_used;
   logic                        do_write;

   function automatic logic [brbq_pkg::ADDR_W-1:0] adv(
      input logic [brbq_pkg::ADDR_W-1:0] p,
      input logic [brbq_pkg::CNT_W-1:0]  c
   );
      logic [brbq_pkg::CNT_W-1:0] n;
      n = {1'b0, p} + brbq_pkg::CNT_W'(1);
      return (n >= c) ? '0 : n[brbq_pkg::ADDR_W-1:0];
   endfunction

   assign free_b      = (used_ff < cap_ff) ? cap_ff - used_ff : '0;
   assign len_gt_free = brbq_pkg::CMP_W'(length) > brbq_pkg::CMP_W'(free_b);
   assign len_gt_used = brbq_pkg::CMP_W'(length) > brbq_pkg::CMP_W'(used_ff);

   // effective capacity: zero acts as one, clipped to the store depth
   always_comb begin
      cap_in = cap_ff;
      if (cfg_we) begin
         if (cfg_data == '0) begin
            cap_in = brbq_pkg::CNT_W'(1);
         end else if (cfg_data > DEPTH_C) begin
            cap_in = DEPTH_C;
         end else begin
            cap_in = cfg_data;
         end
      end
   end

   always_comb begin
      head_in    = head_ff;
      wcur_in    = wcur_ff;
      used_in    = used_ff;
      crem_in    = crem_ff;
      ctot_in    = ctot_ff;
      cdisc_in   = cdisc_ff;
      rrem_in    = rrem_ff;
      do_write   = 1'b0;
      rd_en      = 1'b0;
      res.status  = brbq_pkg::ST_OK;
      res.granted = '0;
      res.last    = 1'b0;
      res.popped  = 1'b0;

      unique case (cmd)
         brbq_pkg::CMD_ADD: begin
            if (crem_ff == '0) begin
               if (length == '0) begin
                  res.status = brbq_pkg::ST_OK;
               end else if (len_gt_free) begin
                  cdisc_in   = 1'b1;
                  crem_in    = length - brbq_pkg::LEN_W'(1);
                  res.status = brbq_pkg::ST_NO_SPACE;
               end else begin
                  cdisc_in   = 1'b0;
                  ctot_in    = brbq_pkg::CNT_W'(length);
                  crem_in    = length - brbq_pkg::LEN_W'(1);
                  do_write   = 1'b1;
                  res.status = brbq_pkg::ST_TAKEN;
               end
            end else begin
               crem_in = crem_ff - brbq_pkg::LEN_W'(1);
               if (cdisc_ff) begin
                  res.status = brbq_pkg::ST_NO_SPACE;
               end else begin
                  do_write   = 1'b1;
                  res.status = brbq_pkg::ST_TAKEN;
               end
            end
            // end of chunk: commit or drop the discard mark
            if (res.status != brbq_pkg::ST_OK && crem_in == '0) begin
               if (cdisc_in) begin
                  cdisc_in = 1'b0;
               end else begin
                  used_in    = used_ff + ctot_in;
                  ctot_in    = '0;
                  res.status = brbq_pkg::ST_OK;
               end
            end
            if (do_write) begin
               wcur_in = adv(wcur_ff, cap_ff);
            end
         end
         brbq_pkg::CMD_GET: begin
            if (rrem_ff != '0) begin
               res.status = brbq_pkg::ST_BUSY;
            end else if (length == '0 || (len_gt_used && allow_underflow)) begin
               res.granted = used_ff;
            end else if (len_gt_used) begin
               res.status = brbq_pkg::ST_UNDERFLOW;
            end else begin
               res.granted = brbq_pkg::CNT_W'(length);
            end
            // a busy or failed request leaves no grant pending
            rrem_in = res.granted;
         end
         brbq_pkg::CMD_POP: begin
            if (rrem_ff == '0 || used_ff == '0) begin
               res.status = brbq_pkg::ST_NONE;
            end else begin
               rd_en      = 1'b1;
               res.popped = 1'b1;
               head_in    = adv(head_ff, cap_ff);
               used_in    = used_ff - brbq_pkg::CNT_W'(1);
               rrem_in    = rrem_ff - brbq_pkg::CNT_W'(1);
               res.last   = (rrem_in == '0);
            end
         end
         brbq_pkg::CMD_CLEAR: begin
            head_in  = '0;
            wcur_in  = '0;
            used_in  = '0;
            crem_in  = '0;
            ctot_in  = '0;
            cdisc_in = 1'b0;
            rrem_in  = '0;
         end
         default: begin
            res.status = brbq_pkg::ST_OK;
         end
      endcase
      res.used_count = used_in;
   end

   assign wr.en   = step && do_write;
   assign wr.addr = wcur_ff;
   assign wr.data = data_in;
   assign rd_addr = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= DEPTH_C;
         head_ff  <= '0;
         wcur_ff  <= '0;
         used_ff  <= '0;
         crem_ff  <= '0;
         ctot_ff  <= '0;
         cdisc_ff <= 1'b0;
         rrem_ff  <= '0;
      end else if (cfg_we) begin
         cap_ff   <= cap_in;
         head_ff  <= '0;
         wcur_ff  <= '0;
         used_ff  <= '0;
         crem_ff  <= '0;
         ctot_ff  <= '0;
         cdisc_ff <= 1'b0;
         rrem_ff  <= '0;
      end else if (step) begin
         head_ff  <= head_in;
         wcur_ff  <= wcur_in;
         used_ff  <= used_in;
         crem_ff  <= crem_in;
         ctot_ff  <= ctot_in;
         cdisc_ff <= cdisc_in;
         rrem_ff  <= rrem_in;
      end
   end

   a_used_le_cap : assert property (@(posedge clock) disable iff (reset)
      used_ff <= cap_ff)
      else $error("committed bytes exceed capacity");

   a_grant_le_used : assert property (@(posedge clock) disable iff (reset)
      rrem_ff <= used_ff)
      else $error("pending grant exceeds committed bytes");

   a_ptr_in_range : assert property (@(posedge clock) disable iff (reset)
      ({1'b0, head_ff} < cap_ff) && ({1'b0, wcur_ff} < cap_ff))
      else $error("queue pointer beyond capacity");

endmodule

>>> sv/byte_ring_buffer_queue.sv
// top level of the byte ring buffer queue
//
// circular byte queue over a 4096-byte store. every item is one command: add a byte of a
// chunk (the first byte carries the chunk length, the chunk is taken whole or dropped whole),
// get a grant of committed bytes, pop one granted byte, or clear. one item is accepted per
// cycle while the stage is free or moves on, and each item yields exactly one result item: it
// updates the queue state and issues its store read in the accept cycle, then passes through a
// stage register (holding the registered store read) into the output register, so the block
// can take one more item while a result waits on a stalled output. throughput is one item per
// cycle while the output drains, set by the single-port-per-direction byte store. a write on
// the csr channel sets the capacity (0 acts as 1, above 4096 acts as 4096) and empties the
// queue; it is only to be issued with no item in flight. store contents survive a clear.
module byte_ring_buffer_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   // input items
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [15:0] length, [23:16] data_in, [24] allow_underflow, rest zero
   input  logic [brbq_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] command
   input  logic [1:0]                           req_tuser,
   // result items
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [12:0] granted, [20:13] data_out, [33:21] used_count, rest zero
   output logic [brbq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [2:0] status
   output logic [2:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   // capacity register
   input  logic                                 csr_tvalid,
   output logic                                 csr_tready,
   // [12:0] capacity, rest ignored
   input  logic [brbq_pkg::CSR_DATA_W-1:0]      csr_tdata
);

   localparam int DO_LO = brbq_pkg::CNT_W;
   localparam int UC_LO = DO_LO + brbq_pkg::BYTE_W;
   localparam int FILL  = brbq_pkg::RSP_DATA_W - UC_LO - brbq_pkg::CNT_W;

   logic                        accept;
   logic                        stg_move;
   logic                        out_take;
   logic                        cfg_we;

   brbq_pkg::result_type        res;
   brbq_pkg::wr_type            wr;
   logic                        rd_en;
   logic [brbq_pkg::ADDR_W-1:0] rd_addr;
   logic [brbq_pkg::BYTE_W-1:0] rd_data;

   // stage register: result fields wait here next to the registered store read
   logic                        stg_valid_ff, stg_valid_in;
   brbq_pkg::result_type        stg_ff;

   // output register
   logic                        out_valid_ff, out_valid_in;
   brbq_pkg::result_type        out_ff;
   logic [brbq_pkg::BYTE_W-1:0] out_data_ff;

   assign csr_tready = 1'b1;
   assign cfg_we     = csr_tvalid;

   // output register frees when empty or taken; stage frees when it moves on
   assign out_take   = out_valid_ff && rsp_tready;
   assign stg_move   = stg_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !stg_valid_ff || stg_move;
   assign accept     = req_tvalid && req_tready;

   brbq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .step            (accept),
      .cmd             (brbq_pkg::cmd_type'(req_tuser)),
      .length          (req_tdata[brbq_pkg::LEN_W-1:0]),
      .data_in         (req_tdata[brbq_pkg::LEN_W +: brbq_pkg::BYTE_W]),
      .allow_underflow (req_tdata[brbq_pkg::LEN_W + brbq_pkg::BYTE_W]),
      .cfg_we          (cfg_we),
      .cfg_data        (csr_tdata[brbq_pkg::CNT_W-1:0]),
      .res             (res),
      .wr              (wr),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr)
   );

   brbq_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (accept && rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (accept) begin
         stg_valid_in = 1'b1;
      end else if (stg_move) begin
         stg_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (stg_move) begin
         out_valid_in = 1'b1;
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         stg_ff <= res;
      end
      if (stg_move) begin
         out_ff      <= stg_ff;
         out_data_ff <= stg_ff.popped ? rd_data : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {{FILL{1'b0}}, out_ff.used_count, out_data_ff, out_ff.granted};

endmodule

>>> tb/tb_byte_ring_buffer_queue.sv
// self-checking testbench for the byte ring buffer queue
`timescale 1ns / 1ps

module tb_byte_ring_buffer_queue;

   localparam int PHASES      = 9;    // capacity settings after the opening run
   localparam int PHASE_ITEMS = 200;  // items offered per setting
   localparam int HOLD_CYCLES = 300;  // long receiver hold-off
   localparam int SETTLE      = 20;   // cycles left for the pipeline to empty
   localparam int STALL_LIMIT = 5000; // cycles without any handshake
   localparam int SHOWN_MAX   = 10;

   // one result item as the block reports it
   typedef struct packed {
      brbq_pkg::status_type                 status;
      logic [brbq_pkg::CNT_W-1:0]           granted;
      logic [brbq_pkg::BYTE_W-1:0]          data;
      logic                                 last;
      logic [brbq_pkg::CNT_W-1:0]           used;
   } rsp_item_type;

   // one row of the opening run, with its result typed in
   typedef struct packed {
      brbq_pkg::cmd_type                    cmd;
      logic [brbq_pkg::LEN_W-1:0]           len;
      logic [brbq_pkg::BYTE_W-1:0]          din;
      logic                                 allow;
      rsp_item_type                         want;
   } opening_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   // [15:0] length, [23:16] data_in, [24] allow_underflow
   logic [brbq_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [1:0]                      req_tuser;   // [1:0] command
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   // [12:0] granted, [20:13] data_out, [33:21] used_count
   logic [brbq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]                      rsp_tuser;   // [2:0] status
   logic                            rsp_tlast;
   logic                            csr_tvalid;
   logic                            csr_tready;
   logic [brbq_pkg::CSR_DATA_W-1:0] csr_tdata;   // [12:0] capacity

   byte_ring_buffer_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   // shadow copy of the queue, advanced once per accepted item
   logic [brbq_pkg::BYTE_W-1:0] fifo_store [0:brbq_pkg::DEPTH-1];
   logic [brbq_pkg::ADDR_W-1:0] rd_ptr;
   logic [brbq_pkg::ADDR_W-1:0] wr_ptr;
   logic [brbq_pkg::CNT_W-1:0]  held;
   logic [brbq_pkg::LEN_W-1:0]  chunk_left;
   logic [brbq_pkg::CNT_W-1:0]  chunk_size;
   logic                        chunk_dropping;
   logic [brbq_pkg::CNT_W-1:0]  grant_left;
   logic [brbq_pkg::CNT_W-1:0]  capacity;

   rsp_item_type    pending_rsp [$];   // predicted results, oldest first
   opening_row_type opening_rows [0:31];
   int              n_rows;

   int unsigned items_sent;
   int unsigned results_seen;
   int unsigned mismatches;
   int unsigned last_marks;
   int unsigned status_seen [0:7];
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   bit          hold_request;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // queue predictor
   // ---------------------------------------------------------------------------------------

   // capacity in force: zero behaves as one, anything above the store as the store
   function automatic logic [brbq_pkg::CNT_W-1:0] usable_size();
      if (capacity == '0) return brbq_pkg::CNT_W'(1);
      if (capacity > brbq_pkg::CNT_W'(brbq_pkg::DEPTH)) return brbq_pkg::CNT_W'(brbq_pkg::DEPTH);
      return capacity;
   endfunction

   // pointers wrap at the capacity, not at the store size
   function automatic logic [brbq_pkg::ADDR_W-1:0] next_slot(
      input logic [brbq_pkg::ADDR_W-1:0] p
   );
      logic [brbq_pkg::CNT_W-1:0] n;
      n = {1'b0, p} + brbq_pkg::CNT_W'(1);
      return (n >= usable_size()) ? '0 : n[brbq_pkg::ADDR_W-1:0];
   endfunction

   // store contents survive, everything else goes back to empty
   function automatic void empty_queue();
      rd_ptr         = '0;
      wr_ptr         = '0;
      held           = '0;
      chunk_left     = '0;
      chunk_size     = '0;
      chunk_dropping = 1'b0;
      grant_left     = '0;
   endfunction

   task automatic queue_step(input brbq_pkg::cmd_type cmd,
                             input logic [brbq_pkg::LEN_W-1:0] len,
                             input logic [brbq_pkg::BYTE_W-1:0] din, input logic allow,
                             output rsp_item_type res);
      logic [brbq_pkg::CNT_W-1:0] room;
      res = '0;
      res.status = brbq_pkg::ST_OK;
      case (cmd)
         brbq_pkg::CMD_ADD: begin
            if (chunk_left == '0) begin
               // first byte of a chunk: decide take or drop for the whole chunk
               room = (held < usable_size()) ? usable_size() - held : '0;
               if (len == '0) begin
                  res.status = brbq_pkg::ST_OK;
               end else if (len > room) begin
                  chunk_dropping = 1'b1;
                  chunk_left     = len - 1'b1;
                  res.status     = brbq_pkg::ST_NO_SPACE;
               end else begin
                  chunk_dropping     = 1'b0;
                  chunk_size         = len[brbq_pkg::CNT_W-1:0];
                  chunk_left         = len - 1'b1;
                  fifo_store[wr_ptr] = din;
                  wr_ptr             = next_slot(wr_ptr);
                  res.status         = brbq_pkg::ST_TAKEN;
               end
            end else begin
               chunk_left = chunk_left - 1'b1;
               if (chunk_dropping) begin
                  res.status = brbq_pkg::ST_NO_SPACE;
               end else begin
                  fifo_store[wr_ptr] = din;
                  wr_ptr             = next_slot(wr_ptr);
                  res.status         = brbq_pkg::ST_TAKEN;
               end
            end
            // end of chunk: a taken chunk only now counts as held
            if (res.status != brbq_pkg::ST_OK && chunk_left == '0) begin
               if (chunk_dropping) begin
                  chunk_dropping = 1'b0;
               end else begin
                  held       = held + chunk_size;
                  chunk_size = '0;
                  res.status = brbq_pkg::ST_OK;
               end
            end
         end
         brbq_pkg::CMD_GET: begin
            if (grant_left != '0) begin
               res.status = brbq_pkg::ST_BUSY;
            end else if (len == '0 || (len > held && allow)) begin
               res.granted = held;
            end else if (len > held) begin
               res.status = brbq_pkg::ST_UNDERFLOW;
            end else begin
               res.granted = len[brbq_pkg::CNT_W-1:0];
            end
            // a busy or failed get leaves no grant behind
            grant_left = res.granted;
         end
         brbq_pkg::CMD_POP: begin
            if (grant_left == '0 || held == '0) begin
               res.status = brbq_pkg::ST_NONE;
            end else begin
               res.data   = fifo_store[rd_ptr];
               rd_ptr     = next_slot(rd_ptr);
               held       = held - 1'b1;
               grant_left = grant_left - 1'b1;
               res.last   = (grant_left == '0);
            end
         end
         default: begin
            empty_queue();
         end
      endcase
      res.used = held;
   endtask

   // ---------------------------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------------------------

   // offers one item, with random idle cycles ahead of it, and records what should come back
   task automatic present_item(input brbq_pkg::cmd_type cmd,
                               input logic [brbq_pkg::LEN_W-1:0] len,
                               input logic [brbq_pkg::BYTE_W-1:0] din, input logic allow,
                               input bit typed, input rsp_item_type typed_rsp);
      rsp_item_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, allow, din, len};
      do @(posedge clock); while (!req_tready);
      queue_step(cmd, len, din, allow, predicted);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      items_sent++;
   endtask

   task automatic offer_item(input brbq_pkg::cmd_type cmd,
                             input logic [brbq_pkg::LEN_W-1:0] len,
                             input logic [brbq_pkg::BYTE_W-1:0] din, input logic allow);
      present_item(cmd, len, din, allow, 1'b0, '0);
   endtask

   // sender stops until every result is back and the pipeline has emptied
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [brbq_pkg::CNT_W-1:0] value);
      csr_tvalid <= 1'b1;
      csr_tdata  <= {3'd0, value};
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      capacity = value;
      empty_queue();
   endtask

   task automatic add_row(input brbq_pkg::cmd_type cmd, input logic [brbq_pkg::LEN_W-1:0] len,
                          input logic [brbq_pkg::BYTE_W-1:0] din, input logic allow,
                          input brbq_pkg::status_type st,
                          input logic [brbq_pkg::CNT_W-1:0] granted,
                          input logic [brbq_pkg::BYTE_W-1:0] data, input logic last,
                          input logic [brbq_pkg::CNT_W-1:0] used);
      opening_rows[n_rows].cmd          = cmd;
      opening_rows[n_rows].len          = len;
      opening_rows[n_rows].din          = din;
      opening_rows[n_rows].allow        = allow;
      opening_rows[n_rows].want.status  = st;
      opening_rows[n_rows].want.granted = granted;
      opening_rows[n_rows].want.data    = data;
      opening_rows[n_rows].want.last    = last;
      opening_rows[n_rows].want.used    = used;
      n_rows++;
   endtask

   // a single get, pop or clear with random content
   task automatic stray_item();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 20)
         offer_item(brbq_pkg::CMD_CLEAR, 16'($urandom), 8'($urandom), 1'($urandom));
      else if (r < 60)
         offer_item(brbq_pkg::CMD_GET, 16'($urandom_range(held + 4)), 8'($urandom),
                    1'($urandom));
      else
         offer_item(brbq_pkg::CMD_POP, 16'($urandom), 8'($urandom), 1'($urandom));
   endtask

   // one chunk: sized mostly to fit, sometimes exactly full, empty or too large;
   // now and then gets and pops slip in between its bytes, or it is cut short
   task automatic add_chunk();
      int unsigned room;
      int unsigned size;
      int unsigned k;
      int unsigned r;
      bit          cut;
      room = usable_size() - held;
      r    = $urandom_range(99);
      if (room <= 64 && r < 12)
         size = room + 1 + $urandom_range(3);
      else if (room <= 64 && r < 20)
         size = room;
      else if (r < 25)
         size = 0;
      else if (room == 0)
         size = 1 + $urandom_range(2);
      else
         size = 1 + $urandom_range(((room < 16) ? room : 16) - 1);
      offer_item(brbq_pkg::CMD_ADD, 16'(size), 8'($urandom), 1'($urandom));
      k   = 1;
      cut = 1'b0;
      while (k < size && !cut) begin
         r = $urandom_range(99);
         if (r < 2) begin
            offer_item(brbq_pkg::CMD_CLEAR, 16'($urandom), 8'($urandom), 1'($urandom));
            cut = 1'b1;
         end else if (r < 4) begin
            cut = 1'b1;   // the next chunk's first byte lands in this one
         end else begin
            if (r < 12) begin
               if (r[0])
                  offer_item(brbq_pkg::CMD_POP, 16'($urandom), 8'($urandom), 1'($urandom));
               else
                  offer_item(brbq_pkg::CMD_GET, 16'($urandom_range(held)), 8'($urandom),
                             1'($urandom));
            end
            // the length field of later bytes is ignored, so it carries noise
            offer_item(brbq_pkg::CMD_ADD, 16'($urandom), 8'($urandom), 1'($urandom));
            k++;
         end
      end
   endtask

   // a get followed by the pops that drain its grant
   task automatic take_grant();
      int unsigned                r;
      int unsigned                pops;
      logic [brbq_pkg::LEN_W-1:0] ask;
      r = $urandom_range(99);
      if (r < 20)
         ask = '0;
      else if (r < 35)
         ask = 16'(held + 1 + $urandom_range(8));
      else if (r < 42)
         ask = 16'($urandom);
      else
         ask = 16'($urandom_range(held));
      offer_item(brbq_pkg::CMD_GET, ask, 8'($urandom), 1'($urandom));
      // a second get while the grant is open is refused and drops the grant
      if ($urandom_range(99) < 8)
         offer_item(brbq_pkg::CMD_GET, 16'($urandom_range(held)), 8'($urandom),
                    1'($urandom));
      pops = grant_left;
      r    = $urandom_range(99);
      if (r < 15)
         pops = pops + 1;
      else if (r < 25 && pops > 0)
         pops = $urandom_range(pops);
      repeat (pops)
         offer_item(brbq_pkg::CMD_POP, 16'($urandom), 8'($urandom), 1'($urandom));
   endtask

   // ---------------------------------------------------------------------------------------
   // receiver side: random back-pressure, a long hold-off on request, result checking
   // ---------------------------------------------------------------------------------------

   initial begin
      int unsigned  hold_left;
      rsp_item_type got;
      rsp_item_type want;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.status  = brbq_pkg::status_type'(rsp_tuser);
            got.granted = rsp_tdata[12:0];
            got.data    = rsp_tdata[20:13];
            got.last    = rsp_tlast;
            got.used    = rsp_tdata[33:21];
            results_seen++;
            status_seen[rsp_tuser]++;
            if (got.last) last_marks++;
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_MAX)
                  $display("%0t: result with none expected: status %0d granted %0d %s",
                           $realtime, got.status, got.granted,
                           $sformatf("data %02h last %0b used %0d",
                                     got.data, got.last, got.used));
            end else begin
               want = pending_rsp.pop_front();
               if (got.status !== want.status || got.granted !== want.granted ||
                   got.data !== want.data || got.last !== want.last ||
                   got.used !== want.used) begin
                  mismatches++;
                  if (mismatches <= SHOWN_MAX) begin
                     $display("%0t: result %0d: expected status %0d granted %0d %s",
                              $realtime, results_seen, want.status, want.granted,
                              $sformatf("data %02h last %0b used %0d",
                                        want.data, want.last, want.used));
                     $display("%0t: result %0d: got      status %0d granted %0d %s",
                              $realtime, results_seen, got.status, got.granted,
                              $sformatf("data %02h last %0b used %0d",
                                        got.data, got.last, got.used));
                  end
               end
            end
         end
         // hold-off is counted here so the sender keeps pushing meanwhile
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // watchdog: ends the run when no channel has moved for too long
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_tvalid && csr_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("no handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_rsp.size());
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      int                         p;
      int                         i;
      int unsigned                start;
      int unsigned                r;
      logic [brbq_pkg::CNT_W-1:0] cap;
      items_sent   = 0;
      results_seen = 0;
      mismatches   = 0;
      last_marks   = 0;
      hold_request = 1'b0;
      req_idle_pct = 32;
      rsp_idle_pct = 32;
      n_rows       = 0;
      for (i = 0; i < 8; i++) status_seen[i] = 0;
      capacity = brbq_pkg::CNT_W'(brbq_pkg::DEPTH);
      empty_queue();

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_tvalid <= 1'b0;
      csr_tdata  <= '0;

      // opening run at the reset capacity, results typed in
      // empty queue: every kind of request with nothing held
      add_row(brbq_pkg::CMD_POP,   16'd0,    8'h00, 1'b0,
              brbq_pkg::ST_NONE,      13'd0, 8'h00, 1'b0, 13'd0);
      add_row(brbq_pkg::CMD_GET,   16'd0,    8'h00, 1'b0,
              brbq_pkg::ST_OK,        13'd0, 8'h00, 1'b0, 13'd0);
      add_row(brbq_pkg::CMD_GET,   16'd5,    8'h00, 1'b0,
              brbq_pkg::ST_UNDERFLOW, 13'd0, 8'h00, 1'b0, 13'd0);
      add_row(brbq_pkg::CMD_GET,   16'hFFFF, 8'hFF, 1'b1,
              brbq_pkg::ST_OK,        13'd0, 8'h00, 1'b0, 13'd0);
      add_row(brbq_pkg::CMD_ADD,   16'd0,    8'h5A, 1'b0,
              brbq_pkg::ST_OK,        13'd0, 8'h00, 1'b0, 13'd0);
      // oversized chunk is dropped, then abandoned by a clear
      add_row(brbq_pkg::CMD_ADD,   16'hFFFF, 8'hFF, 1'b1,
              brbq_pkg::ST_NO_SPACE,  13'd0, 8'h00, 1'b0, 13'd0);
      add_row(brbq_pkg::CMD_ADD,   16'd0,    8'h00, 1'b0,
              brbq_pkg::ST_NO_SPACE,  13'd0, 8'h00, 1'b0, 13'd0);
      add_row(brbq_pkg::CMD_CLEAR, 16'hFFFF, 8'hFF, 1'b1,
              brbq_pkg::ST_OK,        13'd0, 8'h00, 1'b0, 13'd0);
      // three-byte chunk, committed on its last byte
      add_row(brbq_pkg::CMD_ADD,   16'd3,    8'h00, 1'b0,
              brbq_pkg::ST_TAKEN,     13'd0, 8'h00, 1'b0, 13'd0);
      add_row(brbq_pkg::CMD_ADD,   16'hFFFF, 8'hFF, 1'b1,
              brbq_pkg::ST_TAKEN,     13'd0, 8'h00, 1'b0, 13'd0);
      add_row(brbq_pkg::CMD_ADD,   16'd0,    8'hA5, 1'b0,
              brbq_pkg::ST_OK,        13'd0, 8'h00, 1'b0, 13'd3);
      // grant of two, one pop, then a refused get drops the rest of the grant
      add_row(brbq_pkg::CMD_GET,   16'd2,    8'h00, 1'b0,
              brbq_pkg::ST_OK,        13'd2, 8'h00, 1'b0, 13'd3);
      add_row(brbq_pkg::CMD_POP,   16'd0,    8'h00, 1'b0,
              brbq_pkg::ST_OK,        13'd0, 8'h00, 1'b0, 13'd2);
      add_row(brbq_pkg::CMD_GET,   16'd1,    8'h00, 1'b1,
              brbq_pkg::ST_BUSY,      13'd0, 8'h00, 1'b0, 13'd2);
      add_row(brbq_pkg::CMD_POP,   16'd0,    8'h00, 1'b0,
              brbq_pkg::ST_NONE,      13'd0, 8'h00, 1'b0, 13'd2);
      add_row(brbq_pkg::CMD_GET,   16'd0,    8'h00, 1'b0,
              brbq_pkg::ST_OK,        13'd2, 8'h00, 1'b0, 13'd2);
      add_row(brbq_pkg::CMD_POP,   16'd0,    8'h00, 1'b0,
              brbq_pkg::ST_OK,        13'd0, 8'hFF, 1'b0, 13'd1);
      // pop while a chunk is open only sees committed bytes
      add_row(brbq_pkg::CMD_ADD,   16'd2,    8'h3C, 1'b0,
              brbq_pkg::ST_TAKEN,     13'd0, 8'h00, 1'b0, 13'd1);
      add_row(brbq_pkg::CMD_POP,   16'd0,    8'h00, 1'b0,
              brbq_pkg::ST_OK,        13'd0, 8'hA5, 1'b1, 13'd0);
      add_row(brbq_pkg::CMD_ADD,   16'd0,    8'hC3, 1'b0,
              brbq_pkg::ST_OK,        13'd0, 8'h00, 1'b0, 13'd2);
      // long request fails without underflow allowed, grants all with it
      add_row(brbq_pkg::CMD_GET,   16'hFFFF, 8'h00, 1'b0,
              brbq_pkg::ST_UNDERFLOW, 13'd0, 8'h00, 1'b0, 13'd2);
      add_row(brbq_pkg::CMD_GET,   16'hFFFF, 8'h00, 1'b1,
              brbq_pkg::ST_OK,        13'd2, 8'h00, 1'b0, 13'd2);
      add_row(brbq_pkg::CMD_POP,   16'd0,    8'h00, 1'b0,
              brbq_pkg::ST_OK,        13'd0, 8'h3C, 1'b0, 13'd1);
      // clear drops the open grant too
      add_row(brbq_pkg::CMD_CLEAR, 16'd0,    8'h00, 1'b0,
              brbq_pkg::ST_OK,        13'd0, 8'h00, 1'b0, 13'd0);
      add_row(brbq_pkg::CMD_POP,   16'd0,    8'h00, 1'b0,
              brbq_pkg::ST_NONE,      13'd0, 8'h00, 1'b0, 13'd0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < n_rows; i++)
         present_item(opening_rows[i].cmd, opening_rows[i].len, opening_rows[i].din,
                      opening_rows[i].allow, 1'b1, opening_rows[i].want);

      // random phases, one capacity setting each, extremes among them
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0:       cap = 13'd0;      // acts as one
            1:       cap = 13'd16;
            2:       cap = 13'd8191;   // above the store, acts as the store
            3:       cap = 13'd1;
            4:       cap = 13'd37;
            5:       cap = 13'd4096;
            6:       cap = 13'd5;
            7:       cap = 13'd300;
            default: cap = 13'd2;
         endcase
         wait_idle();
         write_capacity(cap);
         // receiver holds off long enough for the input side to back up
         if (p == 5) hold_request = 1'b1;
         // one phase runs flat out on both sides
         req_idle_pct = (p == 7) ? 0 : 32;
         rsp_idle_pct = (p == 7) ? 0 : 32;
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r < 45)
               add_chunk();
            else if (r < 80)
               take_grant();
            else
               stray_item();
         end
      end

      wait_idle();
      $display("covered %0d items, %0d results checked, over %0d capacity settings",
               items_sent, results_seen, PHASES + 1);
      $display("no-space %0d, underflow %0d, busy %0d, nothing pending %0d, last marks %0d",
               status_seen[brbq_pkg::ST_NO_SPACE], status_seen[brbq_pkg::ST_UNDERFLOW],
               status_seen[brbq_pkg::ST_BUSY], status_seen[brbq_pkg::ST_NONE], last_marks);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
